>>> hdl/assert_macros.svh
// Assertion macros used by the executor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication check, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/fra_pkg.sv
// Package with opcodes, error codes and sequencer states of the executor.
package fra_pkg;

  typedef enum logic [2:0] {
    OP_INPUT = 3'd0,
    OP_ADD   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_MOD   = 3'd4,
    OP_EQL   = 3'd5,
    OP_RSV6  = 3'd6,
    OP_RSV7  = 3'd7
  } op_t;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_DIV_ZERO = 2'd1;
  localparam logic [1:0] ERR_BAD_MOD  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SERIAL,
    ST_FIX,
    ST_WRITE,
    ST_OUT
  } state_t;

  // Control from the sequencer to the serial datapath.
  typedef struct packed {
    logic load;   // capture operands
    logic step;   // one serial step
    logic is_mul; // multiply vs divide
  } dp_ctl_t;

endpackage

>>> hdl/four_register_alu_executor.sv
// Four-register executor: add/input/equal go from fix straight to write and
// output; multiply, divide and modulo run the serial state in between, driving
// the bit-serial shift-add/restoring-divide unit that handles one bit a cycle;
// while a sticky error is pending they skip the serial unit.
// One transaction is in flight at a time; the result register holds until taken.
module four_register_alu_executor #(
  parameter int DATA_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  operation,
  input  logic [1:0]  target_reg,
  input  logic        use_register,
  input  logic [1:0]  source_reg,
  input  logic signed [31:0] immediate,
  input  logic [3:0]  input_digit,
  input  logic        start_of_run,
  input  logic        end_of_run,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic signed [63:0] target_value,
  output logic        run_done,
  output logic        accepted
);
  `include "assert_macros.svh"

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W + 1);

  fra_pkg::state_t state, state_next;
  fra_pkg::op_t    op;
  fra_pkg::dp_ctl_t ctl;

  logic [W-1:0] regs [4];
  logic [1:0]   err;
  logic [1:0]   tgt, src;
  logic         use_r, last;
  logic [31:0]  imm;
  logic [3:0]   digit;
  logic [W-1:0] a, b, ma, mb, res;
  logic [W-1:0] prod, quot, rem;
  logic         neg_a, neg_b, fault, wr;
  logic [1:0]   fault_code;
  logic [CW-1:0] cnt;

  // Operands from captured instruction
  assign a     = regs[tgt];
  assign b     = use_r ? regs[src] : W'({{32{imm[31]}}, imm});
  assign neg_a = a[W-1];
  assign neg_b = b[W-1];
  assign ma    = neg_a ? -a : a;
  assign mb    = neg_b ? -b : b;

  fra_serial_unit #(.W(W)) u_ser (
    .clk(clk), .ctl(ctl),
    .a(op == fra_pkg::OP_MUL ? a : ma),
    .b(op == fra_pkg::OP_MUL ? b : mb),
    .prod(prod), .quot(quot), .rem(rem)
  );

  // Fault detection and result select
  always_comb begin
    fault      = 1'b0;
    fault_code = fra_pkg::ERR_NONE;
    wr         = 1'b1;
    res        = a;
    case (op)
      fra_pkg::OP_INPUT: res = W'(digit);
      fra_pkg::OP_ADD:   res = a + b;
      fra_pkg::OP_MUL:   res = prod;
      fra_pkg::OP_DIV: begin
        if (b == '0) begin
          fault = 1'b1; fault_code = fra_pkg::ERR_DIV_ZERO;
        end
        res = (neg_a ^ neg_b) ? -quot : quot;
      end
      fra_pkg::OP_MOD: begin
        if (neg_a || neg_b || b == '0) begin
          fault = 1'b1; fault_code = fra_pkg::ERR_BAD_MOD;
        end
        res = rem;
      end
      fra_pkg::OP_EQL:   res = W'(a == b);
      default:           wr = 1'b0;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.is_mul = (op == fra_pkg::OP_MUL);
    case (state)
      fra_pkg::ST_IDLE:
        if (in_valid) state_next = fra_pkg::ST_FIX;
      fra_pkg::ST_FIX: begin
        if (err == fra_pkg::ERR_NONE && (op == fra_pkg::OP_MUL ||
            op == fra_pkg::OP_DIV || op == fra_pkg::OP_MOD)) begin
          ctl.load   = 1'b1;
          state_next = fra_pkg::ST_SERIAL;
        end else begin
          state_next = fra_pkg::ST_WRITE;
        end
      end
      fra_pkg::ST_SERIAL: begin
        ctl.step = 1'b1;
        if (cnt == CW'(W - 1)) state_next = fra_pkg::ST_WRITE;
      end
      fra_pkg::ST_WRITE: state_next = fra_pkg::ST_OUT;
      fra_pkg::ST_OUT:
        if (out_ready) state_next = fra_pkg::ST_IDLE;
      default: state_next = fra_pkg::ST_IDLE;
    endcase
  end

  assign in_ready  = (state == fra_pkg::ST_IDLE);
  assign out_valid = (state == fra_pkg::ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fra_pkg::ST_IDLE;
      err   <= fra_pkg::ERR_NONE;
      cnt   <= '0;
      for (int i = 0; i < 4; i++) regs[i] <= '0;
    end else begin
      state <= state_next;
      if (state == fra_pkg::ST_IDLE && in_valid) begin
        op    <= fra_pkg::op_t'(operation);
        tgt   <= target_reg;
        src   <= source_reg;
        use_r <= use_register;
        imm   <= immediate;
        digit <= input_digit;
        last  <= end_of_run;
        if (start_of_run) begin
          err <= fra_pkg::ERR_NONE;
          for (int i = 0; i < 4; i++) regs[i] <= '0;
        end
      end
      if (state == fra_pkg::ST_FIX) cnt <= '0;
      else if (state == fra_pkg::ST_SERIAL) cnt <= cnt + 1'b1;
      // Commit result or error
      if (state == fra_pkg::ST_WRITE && err == fra_pkg::ERR_NONE) begin
        if (fault) err <= fault_code;
        else if (wr) regs[tgt] <= res;
      end
    end
  end

  assign status       = err;
  assign target_value = 64'($signed(regs[tgt]));
  assign run_done     = last;
  assign accepted     = last && err == fra_pkg::ERR_NONE && regs[3] == '0;

  `ASSERT_IMPL(a_no_both, clk, rst, 1'b1, !(in_ready && out_valid))
  `ASSERT_NEXT(a_err_sticky, clk, rst,
    (err != fra_pkg::ERR_NONE && !(in_valid && in_ready && start_of_run)),
    (err == $past(err)))
  `ASSERT_IMPL(a_cnt_bound, clk, rst, state == fra_pkg::ST_SERIAL, cnt < CW'(W))

endmodule

>>> hdl/fra_serial_unit.sv
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
module fra_serial_unit #(
  parameter int W = 64
) (
  input  logic             clk,
  input  fra_pkg::dp_ctl_t ctl,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     prod,
  output logic [W-1:0]     quot,
  output logic [W-1:0]     rem
);

  logic [W-1:0] acc;
  logic [W-1:0] sh;
  logic [W-1:0] opb;
  logic [W:0]   trial;
  logic [W-1:0] rem_sh;

  // Remainder shifted by one with next dividend bit, then trial subtract
  assign rem_sh = {acc[W-2:0], sh[W-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, opb};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc <= '0;
      sh  <= a;
      opb <= b;
    end else if (ctl.step) begin
      if (ctl.is_mul) begin
        // multiplier bits consumed MSB first, product doubles and adds each step
        acc <= (acc << 1) + (sh[W-1] ? opb : '0);
        sh  <= sh << 1;
      end else begin
        if (!trial[W] && !acc[W-1]) begin
          acc <= trial[W-1:0];
          sh  <= {sh[W-2:0], 1'b1};
        end else if (acc[W-1]) begin
          acc <= rem_sh - opb;
          sh  <= {sh[W-2:0], 1'b1};
        end else begin
          acc <= rem_sh;
          sh  <= {sh[W-2:0], 1'b0};
        end
      end
    end
  end

  assign prod = acc;
  assign quot = sh;
  assign rem  = acc;

endmodule

>>> bench/four_register_alu_executor_tb.sv
// Self-checking bench for the executor: directed table, then random programs.
`timescale 1ns / 1ps

module four_register_alu_executor_tb;

  localparam int CYCLE_LIMIT = 400000;

  // Expected result of one instruction
  typedef struct {
    logic [1:0]         status;
    logic signed [63:0] value;
    logic               done;
    logic               acc;
  } exec_result_t;

  // One directed row; has_want marks results typed in by hand
  typedef struct {
    fra_pkg::op_t       op;
    logic [1:0]         tgt;
    logic               use_reg;
    logic [1:0]         src;
    logic signed [31:0] imm;
    logic [3:0]         digit;
    logic               start;
    logic               last;
    logic               has_want;
    logic [1:0]         want_status;
    logic signed [63:0] want_value;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] operation = '0;
  logic [1:0] target_reg = '0;
  logic use_register = 1'b0;
  logic [1:0] source_reg = '0;
  logic signed [31:0] immediate = '0;
  logic [3:0] input_digit = '0;
  logic start_of_run = 1'b0;
  logic end_of_run = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic signed [63:0] target_value;
  logic run_done;
  logic accepted;

  four_register_alu_executor dut (.*);

  always #5 clk = ~clk;

  // Predictor state
  logic signed [63:0] regs_model [4];
  logic [1:0] err_model;
  exec_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  bit hold_off = 1'b0;

  // Compute expected result of one instruction and update model state
  function automatic exec_result_t execute_instr(fra_pkg::op_t op, logic [1:0] tgt,
      logic ur, logic [1:0] src, logic signed [31:0] imm, logic [3:0] dig, logic st,
      logic ls);
    exec_result_t r;
    logic signed [63:0] a, b;
    logic [63:0] ma, mb, q;
    if (st) begin
      for (int i = 0; i < 4; i++) regs_model[i] = '0;
      err_model = fra_pkg::ERR_NONE;
    end
    b = ur ? regs_model[src] : 64'(imm);
    a = regs_model[tgt];
    if (err_model == fra_pkg::ERR_NONE) begin
      case (op)
        fra_pkg::OP_INPUT: regs_model[tgt] = {60'd0, dig};
        fra_pkg::OP_ADD:   regs_model[tgt] = a + b;
        fra_pkg::OP_MUL:   regs_model[tgt] = a * b;
        fra_pkg::OP_DIV: begin
          if (b == 0) err_model = fra_pkg::ERR_DIV_ZERO;
          else begin
            ma = a[63] ? -a : a;
            mb = b[63] ? -b : b;
            q = ma / mb;
            regs_model[tgt] = (a[63] != b[63]) ? -q : q;
          end
        end
        fra_pkg::OP_MOD: begin
          if (a[63] || b[63] || b == 0) err_model = fra_pkg::ERR_BAD_MOD;
          else regs_model[tgt] = 64'(unsigned'(a) % unsigned'(b));
        end
        fra_pkg::OP_EQL:   regs_model[tgt] = (a == b) ? 64'd1 : 64'd0;
        default: ;
      endcase
    end
    r.status = err_model;
    r.value = regs_model[tgt];
    r.done = ls;
    r.acc = ls && err_model == fra_pkg::ERR_NONE && regs_model[3] == 0;
    return r;
  endfunction

  // Drive one transaction and wait until it is taken; valid stays up for the next one
  task automatic send_instr(fra_pkg::op_t op, logic [1:0] tgt, logic ur, logic [1:0] src,
      logic signed [31:0] imm, logic [3:0] dig, logic st, logic ls);
    while (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pending_results = {pending_results,
                       execute_instr(op, tgt, ur, src, imm, dig, st, ls)};
    in_valid <= 1'b1;
    operation <= op;
    target_reg <= tgt;
    use_register <= ur;
    source_reg <= src;
    immediate <= imm;
    input_digit <= dig;
    start_of_run <= st;
    end_of_run <= ls;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_imm();
    case ($urandom_range(5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -1;
      3: return 32'($urandom_range(20)) - 5;
      default: return $urandom;
    endcase
  endfunction

  // Random program: start, mixed extreme/small/random values, some error-prone ops
  task automatic send_program();
    int len;
    fra_pkg::op_t op;
    len = $urandom_range(1, 10);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) < 3) op = fra_pkg::OP_INPUT;
      else if ($urandom_range(19) == 0) op = fra_pkg::op_t'($urandom_range(7));
      else op = fra_pkg::op_t'($urandom_range(1, 5));
      send_instr(op, 2'($urandom), 1'($urandom), 2'($urandom), rand_imm(),
                 4'($urandom), i == 0 || $urandom_range(29) == 0, i == len - 1);
    end
  endtask

  // Receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= !(rcv_idle > 0 && $urandom_range(99) < rcv_idle);
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin
    exec_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: actual value %0d", $time, target_value);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (status !== e.status) begin
          $display("%0t status: expected %0d actual %0d", $time, e.status, status);
          errors++;
        end
        if (target_value !== e.value) begin
          $display("%0t target_value: expected %0d actual %0d", $time, e.value,
                   target_value);
          errors++;
        end
        if (run_done !== e.done) begin
          $display("%0t run_done: expected %0b actual %0b", $time, e.done, run_done);
          errors++;
        end
        if (accepted !== e.acc) begin
          $display("%0t accepted: expected %0b actual %0b", $time, e.acc, accepted);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[four_register_alu_executor] ERROR");
      $finish;
    end
  end

  // Long receiver hold-off in its own process
  task automatic long_hold();
    hold_off = 1'b1;
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
  endtask

  row_t directed[$];

  function automatic row_t mk(fra_pkg::op_t op, logic [1:0] tgt, logic ur, logic [1:0] src,
      logic signed [31:0] imm, logic [3:0] dig, logic st, logic ls,
      logic hw = 1'b0, logic [1:0] ws = fra_pkg::ERR_NONE, logic signed [63:0] wv = 0);
    row_t r;
    r = '{op, tgt, ur, src, imm, dig, st, ls, hw, ws, wv};
    return r;
  endfunction

  initial begin
    exec_result_t e;
    for (int i = 0; i < 4; i++) regs_model[i] = '0;
    err_model = fra_pkg::ERR_NONE;

    // Directed table: extremes, every opcode, error and overflow cases
    directed = {directed, mk(fra_pkg::OP_ADD, 2'd0, 1'b0, 2'd0, 32'sh7fff_ffff, 4'd0,
                             1'b0, 1'b0, 1'b1, fra_pkg::ERR_NONE, 64'sh7fff_ffff)};
    directed = {directed, mk(fra_pkg::OP_ADD, 2'd1, 1'b0, 2'd0, 32'sh8000_0000, 4'd0,
                             1'b0, 1'b0, 1'b1, fra_pkg::ERR_NONE, -64'sh8000_0000)};
    directed = {directed, mk(fra_pkg::OP_INPUT, 2'd2, 1'b0, 2'd0, 0, 4'd15, 1'b0, 1'b0,
                             1'b1, fra_pkg::ERR_NONE, 64'sd15)};
    directed = {directed, mk(fra_pkg::OP_MUL, 2'd0, 1'b1, 2'd0, 0, 4'd0, 1'b0, 1'b0)};
    directed = {directed, mk(fra_pkg::OP_MUL, 2'd0, 1'b1, 2'd0, 0, 4'd0, 1'b0, 1'b0)};
    directed = {directed, mk(fra_pkg::OP_MUL, 2'd1, 1'b1, 2'd1, 0, 4'd0, 1'b0, 1'b0)};
    directed = {directed, mk(fra_pkg::OP_MUL, 2'd1, 1'b1, 2'd1, 0, 4'd0, 1'b0, 1'b0)};
    directed = {directed, mk(fra_pkg::OP_DIV, 2'd1, 1'b0, 2'd0, -1, 4'd0, 1'b0, 1'b0)};
    directed = {directed, mk(fra_pkg::OP_DIV, 2'd0, 1'b0, 2'd0, -7, 4'd0, 1'b0, 1'b0)};
    directed = {directed, mk(fra_pkg::OP_DIV, 2'd2, 1'b1, 2'd0, 0, 4'd0, 1'b0, 1'b0)};
    directed = {directed, mk(fra_pkg::OP_EQL, 2'd3, 1'b1, 2'd3, 0, 4'd0, 1'b0, 1'b0,
                             1'b1, fra_pkg::ERR_NONE, 64'sd1)};
    directed = {directed, mk(fra_pkg::OP_RSV6, 2'd0, 1'b0, 2'd0, 0, 4'd0, 1'b0, 1'b0)};
    directed = {directed, mk(fra_pkg::OP_RSV7, 2'd1, 1'b1, 2'd2, -1, 4'd9, 1'b0, 1'b0)};
    directed = {directed, mk(fra_pkg::OP_MOD, 2'd2, 1'b0, 2'd0, 4, 4'd0, 1'b0, 1'b0)};
    directed = {directed, mk(fra_pkg::OP_MOD, 2'd2, 1'b0, 2'd0, 0, 4'd0, 1'b0, 1'b1,
                             1'b1, fra_pkg::ERR_BAD_MOD, 64'sd0)};
    directed = {directed, mk(fra_pkg::OP_INPUT, 2'd3, 1'b0, 2'd0, 0, 4'd0, 1'b1, 1'b1,
                             1'b1, fra_pkg::ERR_NONE, 64'sd0)};
    directed = {directed, mk(fra_pkg::OP_DIV, 2'd0, 1'b0, 2'd0, 0, 4'd0, 1'b0, 1'b0,
                             1'b1, fra_pkg::ERR_DIV_ZERO, 64'sd0)};
    directed = {directed, mk(fra_pkg::OP_INPUT, 2'd0, 1'b0, 2'd0, 0, 4'd5, 1'b0, 1'b1,
                             1'b1, fra_pkg::ERR_DIV_ZERO, 64'sd0)};
    directed = {directed, mk(fra_pkg::OP_INPUT, 2'd0, 1'b0, 2'd0, 0, 4'd8, 1'b1, 1'b0)};
    directed = {directed, mk(fra_pkg::OP_MOD, 2'd0, 1'b0, 2'd0, -3, 4'd0, 1'b0, 1'b1,
                             1'b1, fra_pkg::ERR_BAD_MOD, 64'sd8)};
    directed = {directed, mk(fra_pkg::OP_INPUT, 2'd1, 1'b0, 2'd0, 0, 4'd9, 1'b1, 1'b0)};
    directed = {directed, mk(fra_pkg::OP_MOD, 2'd1, 1'b0, 2'd0, 4, 4'd0, 1'b0, 1'b0,
                             1'b1, fra_pkg::ERR_NONE, 64'sd1)};
    directed = {directed, mk(fra_pkg::OP_ADD, 2'd3, 1'b0, 2'd0, 1, 4'd0, 1'b0, 1'b1)};

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send_instr(directed[i].op, directed[i].tgt, directed[i].use_reg, directed[i].src,
                 directed[i].imm, directed[i].digit, directed[i].start, directed[i].last);
      e = pending_results[$];
      if (directed[i].has_want && (e.status !== directed[i].want_status ||
          e.value !== directed[i].want_value)) begin
        $display("%0t row %0d table: expected %0d/%0d actual %0d/%0d", $time, i,
                 directed[i].want_status, directed[i].want_value, e.status, e.value);
        errors++;
      end
    end

    // Sender pauses until every expected result has arrived
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    // Long receiver hold-off while the sender keeps offering
    fork
      long_hold();
      repeat (4) send_program();
    join

    // Three phases of sender and receiver idling, the last with none
    snd_idle = 14; rcv_idle = 80;
    repeat (28) send_program();
    snd_idle = 80; rcv_idle = 14;
    repeat (28) send_program();
    snd_idle = 0; rcv_idle = 0;
    repeat (28) send_program();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("[four_register_alu_executor] OK");
    else $display("[four_register_alu_executor] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/fra_pkg.sv
hdl/fra_serial_unit.sv
hdl/four_register_alu_executor.sv
bench/four_register_alu_executor_tb.sv
